// ===== sv/pcfd_pkg.sv =====
// Shared constants, result codes and controller/datapath handshake structs.
package pcfd_pkg;

  localparam int          MAX_BYTES_DEF = 64;
  localparam logic [31:0] SYNC_RESET    = 32'hAAAA_CCCA;

  localparam logic [2:0]  GRP_ZERO = 3'b100;
  localparam logic [2:0]  GRP_ONE  = 3'b110;
  localparam logic [7:0]  BYTE_FF  = 8'hFF;
  localparam logic [7:0]  BYTE_AA  = 8'hAA;

  localparam logic [1:0]  KIND_SENDER  = 2'd0;
  localparam logic [1:0]  KIND_MESSAGE = 2'd1;
  localparam logic [1:0]  KIND_STATUS  = 2'd2;

  localparam logic [2:0]  STAT_OK      = 3'd0;
  localparam logic [2:0]  STAT_CHKSUM  = 3'd1;
  localparam logic [2:0]  STAT_SLEN    = 3'd2;
  localparam logic [2:0]  STAT_LINE    = 3'd3;
  localparam logic [2:0]  STAT_NOTERM  = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input item taken this cycle
    logic fetch;      // prime read of buffer entry 1
    logic load_byte;  // move buffered byte into output register
    logic load_final; // load closing ok status
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic burst;        // current item closes a good frame
    logic burst_empty;  // good frame has no sender/message bytes
    logic ptr_last;     // read pointer sits on the last byte to emit
  } stat_t;

endpackage

// ===== sv/pcfd_ctrl.sv =====
// Sequencing FSM: input acceptance and the byte burst of a good frame.
module pcfd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pcfd_pkg::stat_t stat,
  output pcfd_pkg::cmd_t  cmd
);
  import pcfd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FETCH  = 4'b0010,
    ST_EMIT   = 4'b0100,
    ST_STATUS = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    state_nxt      = state_r;
    case (state_r)
      ST_IDLE: begin
        in_ready   = stat.out_free;
        cmd.accept = in_valid && stat.out_free;
        if (cmd.accept && stat.burst) begin
          state_nxt = stat.burst_empty ? ST_STATUS : ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_byte = 1'b1;
          if (stat.ptr_last) begin
            state_nxt = ST_STATUS;
          end
        end
      end
      ST_STATUS: begin
        if (stat.out_free) begin
          cmd.load_final = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_burst_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && stat.burst) |=> (state_r == ST_FETCH || state_r == ST_STATUS))
    else $error("good frame did not start a burst");
  a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_final |=> (state_r == ST_IDLE))
    else $error("closing status did not return to idle");
  a_last_byte_to_status: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_byte && stat.ptr_last) |=> (state_r == ST_STATUS))
    else $error("last buffered byte not followed by status");
`endif

endmodule

// ===== sv/pcfd_datapath.sv =====
// Sync hunt, line decoder, frame buffer, checksum and output register.
module pcfd_datapath #(
  parameter int MaxBytes = pcfd_pkg::MAX_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_symbol,
  input  logic            in_capture_end,
  input  logic            cfg_wr_en,
  input  logic [31:0]     cfg_wr_data,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_value,
  output logic [2:0]      out_status,
  output logic            out_last,
  input  pcfd_pkg::cmd_t  cmd,
  output pcfd_pkg::stat_t stat
);
  import pcfd_pkg::*;

  localparam int CW   = $clog2(MaxBytes + 1);
  localparam int AW   = $clog2(MaxBytes);
  localparam int CMPW = ((CW > 8) ? CW : 8) + 2;

  logic [31:0]   sync_r;
  logic          hunt_r;
  logic [31:0]   win_r;
  logic [2:0]    grp_r;
  logic [1:0]    gcnt_r;
  logic [7:0]    bsh_r;
  logic [2:0]    bcnt_r;
  logic [CW-1:0] byte_cnt_r;
  logic [7:0]    sum_r;
  logic          term_r;
  logic          prev_ff_r;
  logic [7:0]    sl_r;
  logic [AW-1:0] last_idx_r;
  logic [AW-1:0] ptr_r;
  logic [7:0]    rd_data_r;
  logic [7:0]    mem [MaxBytes];

  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic [7:0]    out_value_r;
  logic [2:0]    out_status_r;
  logic          out_last_r;

  logic [31:0]   win_shift;
  logic          sync_hit;
  logic [2:0]    grp_shift;
  logic          grp_done, grp_bad, bit_good;
  logic [7:0]    byte_new;
  logic          byte_done, chk_bad, sl_bad, full;
  logic          close, store, frame_ok, frame_exit;
  logic          hunt_after, end_err, emit_status, clr_dec;
  logic [2:0]    err_code;
  logic [AW-1:0] rd_addr;
  logic          out_load;

  // ---- step decode ----
  always_comb begin
    win_shift = {win_r[30:0], in_symbol};
    sync_hit  = (win_shift == sync_r);
    grp_shift = {grp_r[1:0], in_symbol};
    grp_done  = !hunt_r && (gcnt_r == 2'd2);
    grp_bad   = grp_done && (grp_shift != GRP_ZERO) && (grp_shift != GRP_ONE);
    bit_good  = grp_done && !grp_bad;
    byte_new  = {bsh_r[6:0], grp_shift[1]};
    byte_done = bit_good && (bcnt_r == 3'd7);
    chk_bad   = (sum_r != byte_new);
    sl_bad    = (CMPW'(sl_r) + CMPW'(3)) > CMPW'(byte_cnt_r);
    full      = (byte_cnt_r >= CW'(MaxBytes));
    close     = byte_done && (term_r || full);
    store     = byte_done && !term_r && !full;
    frame_ok  = byte_done && term_r && !chk_bad && !sl_bad;
    frame_exit = grp_bad || close;
    hunt_after = hunt_r ? !sync_hit : frame_exit;
    end_err   = in_capture_end && !hunt_after;
    emit_status = (frame_exit && !frame_ok) || end_err;
    clr_dec   = (hunt_r && sync_hit) || frame_exit || in_capture_end;

    if (grp_bad) begin
      err_code = STAT_LINE;
    end else if (close && term_r && chk_bad) begin
      err_code = STAT_CHKSUM;
    end else if (close && term_r) begin
      err_code = STAT_SLEN;
    end else if (close) begin
      err_code = STAT_NOTERM;
    end else begin
      err_code = STAT_LINE;
    end
  end

  // ---- decoder and sync state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r     <= SYNC_RESET;
      hunt_r     <= 1'b1;
      win_r      <= '0;
      grp_r      <= '0;
      gcnt_r     <= '0;
      bsh_r      <= '0;
      bcnt_r     <= '0;
      byte_cnt_r <= '0;
      sum_r      <= '0;
      term_r     <= 1'b0;
      prev_ff_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sync_r <= cfg_wr_data;
      end
      if (cmd.accept) begin
        hunt_r <= hunt_after || in_capture_end;
        if (in_capture_end || (!hunt_r && frame_exit)) begin
          win_r <= '0;
        end else if (hunt_r) begin
          win_r <= win_shift;
        end
        if (clr_dec) begin
          grp_r      <= '0;
          gcnt_r     <= '0;
          bsh_r      <= '0;
          bcnt_r     <= '0;
          byte_cnt_r <= '0;
          sum_r      <= '0;
          term_r     <= 1'b0;
          prev_ff_r  <= 1'b0;
        end else if (!hunt_r) begin
          gcnt_r <= grp_done ? 2'd0 : gcnt_r + 2'd1;
          grp_r  <= grp_done ? 3'd0 : grp_shift;
          if (bit_good) begin
            bcnt_r <= bcnt_r + 3'd1;
            bsh_r  <= byte_done ? 8'd0 : byte_new;
          end
          if (store) begin
            byte_cnt_r <= byte_cnt_r + CW'(1);
            sum_r      <= sum_r + byte_new;
            prev_ff_r  <= (byte_new == BYTE_FF);
            if (prev_ff_r && (byte_new == BYTE_AA)) begin
              term_r <= 1'b1;
            end
          end
        end
      end
    end
  end

  // ---- frame buffer ----
  always_comb begin
    if (cmd.fetch) begin
      rd_addr = AW'(1);
    end else if (cmd.load_byte) begin
      rd_addr = ptr_r + AW'(1);
    end else begin
      rd_addr = ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && store) begin
      mem[byte_cnt_r[AW-1:0]] <= byte_new;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && store && (byte_cnt_r == '0)) begin
      sl_r <= byte_new;
    end
    if (cmd.accept && frame_ok) begin
      last_idx_r <= AW'(byte_cnt_r - CW'(3));
    end
    if (cmd.fetch || cmd.load_byte) begin
      ptr_r <= rd_addr;
    end
  end

  // ---- output register ----
  assign out_load = (cmd.accept && emit_status) || cmd.load_byte || cmd.load_final;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      out_kind_r   <= (CMPW'(ptr_r) <= CMPW'(sl_r)) ? KIND_SENDER : KIND_MESSAGE;
      out_value_r  <= rd_data_r;
      out_status_r <= STAT_OK;
      out_last_r   <= 1'b0;
    end else if (cmd.load_final) begin
      out_kind_r   <= KIND_STATUS;
      out_value_r  <= 8'd0;
      out_status_r <= STAT_OK;
      out_last_r   <= 1'b1;
    end else if (cmd.accept && emit_status) begin
      out_kind_r   <= KIND_STATUS;
      out_value_r  <= 8'd0;
      out_status_r <= err_code;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  always_comb begin
    stat.out_free    = !out_valid_r || out_ready;
    stat.burst       = frame_ok;
    stat.burst_empty = (byte_cnt_r == CW'(3));
    stat.ptr_last    = (ptr_r == last_idx_r);
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= CW'(MaxBytes))
    else $error("byte count beyond buffer");
  a_term_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
    term_r |-> (byte_cnt_r >= CW'(2)) && !hunt_r)
    else $error("terminator flag without FF AA pair in a frame");
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_byte |-> (ptr_r != '0) && (ptr_r <= last_idx_r))
    else $error("emitted buffer entry outside sender/message range");
`endif

endmodule

// ===== sv/pwm_chat_frame_decoder_unit.sv =====
// Top level of the line-coded chat frame deframer with additive checksum.
//
//  channel | ports                                         | direction | handshake
//  --------+-----------------------------------------------+-----------+----------------
//  in      | in_symbol, in_capture_end                     | sink      | in_valid/ready
//  out     | out_kind, out_value, out_status, out_last     | source    | out_valid/ready
//  cfg     | cfg_wr_data (sync word)                       | sink      | cfg_wr_en
//
//  Each symbol item is taken on the edge that accepts it; a status result is registered on
//  that same edge and the next item can enter as soon as the output register frees.
//  A good frame's checksum item is followed by a burst: a prime of the buffer read,
//  then one byte per cycle while the output is free (index of FF minus one bytes) and a
//  closing status, while the input waits; a frame with no bytes to emit skips the
//  prime step and goes straight to the closing status.
//  Reset (rst_n low, synchronous) returns to sync hunt and loads the default sync
//  word; the frame buffer needs no clearing, only entries already filled are read.
//  Output stalls hold the burst in place; the input waits while the burst runs.
module pwm_chat_frame_decoder_unit #(
  parameter int MaxBytes = pcfd_pkg::MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // symbol items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_symbol,
  input  logic        in_capture_end,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_value,
  output logic [2:0]  out_status,
  output logic        out_last,
  // sync word register
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import pcfd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing: decides when an item enters and walks the byte burst
  pcfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // sync window, 3-symbol line decoder, buffer, running sum, output register
  pcfd_datapath #(
    .MaxBytes (MaxBytes)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_symbol      (in_symbol),
    .in_capture_end (in_capture_end),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_value      (out_value),
    .out_status     (out_status),
    .out_last       (out_last),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the line-coded chat frame deframer with additive checksum.
`timescale 1ns / 100ps

module testbench;
  import pcfd_pkg::*;

  localparam int FRAME_BYTES   = MAX_BYTES_DEF;
  localparam int SETTLE_CYCLES = 80;        // longest burst plus margin
  localparam int CYCLE_LIMIT   = 1000000;

  // One result item as the block presents it.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [2:0] status;
    logic       last;
  } frame_result_t;

  typedef enum logic {HUNTING, IN_FRAME} deframe_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_symbol;
  logic        in_capture_end;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_value;
  logic [2:0]  out_status;
  logic        out_last;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  pwm_chat_frame_decoder_unit #(.MaxBytes(FRAME_BYTES)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_symbol     (in_symbol),
    .in_capture_end(in_capture_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_value     (out_value),
    .out_status    (out_status),
    .out_last      (out_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // Results still owed by the block, oldest first.
  frame_result_t pending_results[$];
  // Byte image of the frame the stimulus is about to put on the line.
  logic [7:0]    frame_bytes[$];

  int error_count      = 0;
  int cycle_count      = 0;
  int symbols_total    = 0;
  int symbols_counted  = 0;  // frame symbols only, noise excluded
  int results_promised = 0;
  int results_checked  = 0;
  int frames_sent      = 0;
  bit in_idle_on       = 1'b1;
  bit out_stall_on     = 1'b1;
  bit noise_mode       = 1'b0;

  // ---------------------------------------------------------------------------
  // Deframer prediction: own copy of the sync register and decoder state.
  // ---------------------------------------------------------------------------
  deframe_mode_t mode_m;
  logic [31:0]   sync_m;
  logic [31:0]   window_m;
  logic [2:0]    group_m;
  int            group_cnt_m;
  logic [7:0]    shift_m;
  int            bit_cnt_m;
  logic [7:0]    frame_store_m[FRAME_BYTES];
  int            count_m;
  logic [7:0]    sum_m;
  bit            term_m;

  function automatic void owe_result(input logic [1:0] kind, input logic [7:0] value,
                                     input logic [2:0] status, input logic last);
    frame_result_t r;
    r.kind   = kind;
    r.value  = value;
    r.status = status;
    r.last   = last;
    pending_results.push_back(r);
    results_promised++;
  endfunction

  function automatic void clear_decoder_m();
    group_m     = '0;
    group_cnt_m = 0;
    shift_m     = '0;
    bit_cnt_m   = 0;
    count_m     = 0;
    sum_m       = '0;
    term_m      = 1'b0;
  endfunction

  function automatic void back_to_hunt();
    mode_m   = HUNTING;
    window_m = '0;
    clear_decoder_m();
  endfunction

  // A completed byte: buffer it, close the frame when the buffer is full, or, after FF AA, treat it as the checksum.
  function automatic void absorb_byte(input logic [7:0] b, output bit closed);
    int ff_at;
    int sl;
    int i;
    closed = 1'b0;
    if (term_m) begin
      ff_at  = count_m - 2;
      closed = 1'b1;
      if (sum_m != b) begin
        owe_result(KIND_STATUS, 8'h00, STAT_CHKSUM, 1'b1);
      end else begin
        sl = int'(frame_store_m[0]);
        if (1 + sl > ff_at) begin
          owe_result(KIND_STATUS, 8'h00, STAT_SLEN, 1'b1);
        end else begin
          for (i = 1; i < ff_at; i++)
            owe_result((i <= sl) ? KIND_SENDER : KIND_MESSAGE, frame_store_m[i],
                       STAT_OK, 1'b0);
          owe_result(KIND_STATUS, 8'h00, STAT_OK, 1'b1);
        end
      end
    end else if (count_m >= FRAME_BYTES) begin
      closed = 1'b1;
      owe_result(KIND_STATUS, 8'h00, STAT_NOTERM, 1'b1);
    end else begin
      frame_store_m[count_m] = b;
      sum_m = sum_m + b;
      if (b == BYTE_AA && count_m >= 1 && frame_store_m[count_m - 1] == BYTE_FF)
        term_m = 1'b1;
      count_m++;
    end
  endfunction

  function automatic void deframe_symbol(input logic sym, input logic fin);
    bit closed;
    closed = 1'b0;
    if (mode_m == HUNTING) begin
      window_m = {window_m[30:0], sym};
      if (window_m == sync_m) begin
        mode_m = IN_FRAME;
        clear_decoder_m();
      end
    end else begin
      group_m = {group_m[1:0], sym};
      group_cnt_m++;
      if (group_cnt_m >= 3) begin
        group_cnt_m = 0;
        if (group_m != GRP_ZERO && group_m != GRP_ONE) begin
          // broken line code closes the frame; a capture end on it adds nothing
          owe_result(KIND_STATUS, 8'h00, STAT_LINE, 1'b1);
          back_to_hunt();
          return;
        end
        shift_m = {shift_m[6:0], (group_m == GRP_ONE)};
        group_m = '0;
        bit_cnt_m++;
        if (bit_cnt_m >= 8) begin
          bit_cnt_m = 0;
          absorb_byte(shift_m, closed);
          shift_m = '0;
          if (closed) back_to_hunt();
        end
      end
    end
    if (fin) begin
      if (mode_m == IN_FRAME) begin
        owe_result(KIND_STATUS, 8'h00, STAT_LINE, 1'b1);
        back_to_hunt();
      end
      window_m = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit, result checking, output stalls
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void compare_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with none expected, actual kind %0h value %0h %s",
                 $time, out_kind, out_value,
                 $sformatf("status %0h last %0h", out_status, out_last));
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("kind", 8'(want.kind), 8'(out_kind));
        compare_field("value", want.value, out_value);
        compare_field("status", 8'(want.status), 8'(out_status));
        compare_field("last", 8'(want.last), 8'(out_last));
        results_checked++;
      end
    end
  end

  // Receiver: per result item, hold ready low first for a random stall when stalls are on.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = out_stall_on ? $urandom_range(0, 8) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sends one symbol item after a random gap; prediction runs on acceptance.
  task automatic send_symbol(input logic sym, input logic fin);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_symbol      <= sym;
    in_capture_end <= fin;
    do @(posedge clk); while (!in_ready);
    deframe_symbol(sym, fin);
    symbols_total++;
    if (!noise_mode) symbols_counted++;
  endtask

  task automatic send_group(input logic [2:0] grp, input logic fin);
    send_symbol(grp[2], 1'b0);
    send_symbol(grp[1], 1'b0);
    send_symbol(grp[0], fin);
  endtask

  // Sync pattern MSB first; stops as soon as the block would lock.
  task automatic send_sync();
    int i;
    if (mode_m == IN_FRAME) send_symbol(1'b0, 1'b1);  // abort a stray frame first
    for (i = 31; i >= 0 && mode_m == HUNTING; i--)
      send_symbol(sync_m[i], 1'b0);
  endtask

  // Line-codes the first 'upto' bytes of the frame image; optional fin on the very last symbol.
  task automatic send_frame_bytes(input int upto, input bit fin_last);
    int k;
    int j;
    for (k = 0; k < upto; k++)
      for (j = 7; j >= 0; j--)
        send_group(frame_bytes[k][j] ? GRP_ONE : GRP_ZERO,
                   fin_last && k == upto - 1 && j == 0);
  endtask

  task automatic send_frame(input bit fin_last);
    send_sync();
    send_frame_bytes(frame_bytes.size(), fin_last);
    frames_sent++;
  endtask

  function automatic void begin_frame(input logic [7:0] sender_len);
    frame_bytes.delete();
    frame_bytes.push_back(sender_len);
  endfunction

  // Body bytes never form an early FF AA pair.
  function automatic void add_byte(input logic [7:0] b);
    if (frame_bytes.size() > 0 && frame_bytes[$] == BYTE_FF && b == BYTE_AA) b = 8'hAB;
    frame_bytes.push_back(b);
  endfunction

  function automatic void add_random_body(input int n);
    int k;
    for (k = 0; k < n; k++) add_byte(8'($urandom_range(0, 255)));
  endfunction

  // Terminator plus checksum; a nonzero offset spoils the checksum.
  function automatic void close_frame(input logic [7:0] sum_offset);
    logic [7:0] total;
    total = '0;
    frame_bytes.push_back(BYTE_FF);
    frame_bytes.push_back(BYTE_AA);
    foreach (frame_bytes[k]) total = total + frame_bytes[k];
    frame_bytes.push_back(total + sum_offset);
  endfunction

  // Lower valid, wait for every owed result, then let any burst die out.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(input logic [31:0] word);
    settle_block();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= word;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sync_m = word;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_good_frames();
    begin_frame(8'd0);                       // no sender, no message
    close_frame(8'd0);
    send_frame(1'b0);
    begin_frame(8'd2);                       // FF not followed by AA stays data
    add_byte(8'h00); add_byte(8'hFF); add_byte(8'h7F); add_byte(8'h80); add_byte(8'h01);
    close_frame(8'd0);
    send_frame(1'b0);
    begin_frame(8'd0);                       // AA after non-FF; FF FF AA ending
    add_byte(8'hAA); add_byte(8'h55); add_byte(8'hFF);
    close_frame(8'd0);
    send_frame(1'b1);                        // capture ends on the checksum
    begin_frame(8'd3);                       // sender fills the whole body
    add_random_body(3);
    close_frame(8'd0);
    send_frame(1'b0);
  endtask

  task automatic test_largest_frames();
    begin_frame(8'd61);                      // longest burst, all sender bytes
    add_random_body(61);
    close_frame(8'd0);
    send_frame(1'b0);
    begin_frame(8'd20);
    add_random_body(61);
    close_frame(8'd0);
    send_frame(1'b1);
  endtask

  task automatic test_checksum_errors();
    begin_frame(8'd1);
    add_random_body(2);
    close_frame(8'd1);
    send_frame(1'b0);
    begin_frame(8'd9);                       // bad length too: checksum wins
    add_random_body(2);
    close_frame(8'h80);
    send_frame(1'b0);
  endtask

  task automatic test_sender_length();
    begin_frame(8'd255);
    add_random_body(2);
    close_frame(8'd0);
    send_frame(1'b0);
    begin_frame(8'd4);                       // sender one byte too long, ends on the FF
    add_random_body(3);
    close_frame(8'd0);
    send_frame(1'b0);
  endtask

  task automatic test_line_code();
    logic [2:0] bad_groups[6];
    int g;
    bad_groups = '{3'b000, 3'b001, 3'b010, 3'b011, 3'b101, 3'b111};
    send_sync();                             // broken right after sync
    send_group(3'b111, 1'b0);
    for (g = 0; g < 6; g++) begin
      begin_frame(8'd1);
      add_random_body(1);
      send_sync();
      send_frame_bytes(2, 1'b0);
      send_group(bad_groups[g], g == 5);     // last one also ends the capture
    end
  endtask

  task automatic test_capture_end();
    int i;
    begin_frame(8'd0);                       // ends mid-group
    add_random_body(2);
    send_sync();
    send_frame_bytes(1, 1'b0);
    send_symbol(1'b1, 1'b0);
    send_symbol(1'b1, 1'b1);
    send_sync();                             // ends on a byte boundary
    send_frame_bytes(2, 1'b1);
    send_symbol(1'b0, 1'b1);                 // ends while hunting: no result
    for (i = 31; i >= 1; i--) send_symbol(sync_m[i], 1'b0);
    send_symbol(sync_m[0], 1'b1);            // sync completes on the final symbol
    for (i = 31; i >= 16; i--) send_symbol(sync_m[i], 1'b0);
    send_symbol(sync_m[15], 1'b1);           // window cleared midway through sync
    for (i = 14; i >= 0; i--) send_symbol(sync_m[i], 1'b0);
    begin_frame(8'd1);                       // recovery afterwards
    add_random_body(2);
    close_frame(8'd0);
    send_frame(1'b0);
  endtask

  task automatic test_buffer_overflow();
    frame_bytes.delete();
    add_random_body(FRAME_BYTES + 1);
    send_frame(1'b0);
  endtask

  task automatic test_sync_words();
    logic [31:0] words[3];
    int w;
    words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'(($urandom() << 1) | 1)};
    for (w = 0; w < 3; w++) begin
      write_sync(words[w]);
      begin_frame(8'd1);
      add_random_body(3);
      close_frame(8'd0);
      send_frame(1'b0);
    end
  endtask

  // Mostly well-formed frames with random content, some broken ones and noise.
  task automatic run_random_frame();
    int pick;
    int body;
    int sl;
    int k;
    pick         = $urandom_range(0, 19);
    in_idle_on   = ($urandom_range(0, 3) != 0);
    out_stall_on = ($urandom_range(0, 3) != 0);
    body = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 61) : $urandom_range(0, 8);
    sl   = $urandom_range(0, body);
    begin_frame(8'(sl));
    add_random_body(body);
    if (pick >= 17) begin
      noise_mode = 1'b1;
      for (k = $urandom_range(1, 40); k > 0; k--)
        send_symbol(1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0));
      noise_mode = 1'b0;
    end else if (pick == 16 && $urandom_range(0, 3) == 0) begin
      frame_bytes.delete();
      add_random_body(FRAME_BYTES + 1);
      send_frame(1'b0);
    end else if (pick == 15) begin
      send_sync();
      send_frame_bytes($urandom_range(0, frame_bytes.size()), 1'b0);
      for (k = $urandom_range(0, 23); k > 0; k--)
        send_symbol(1'($urandom_range(0, 1)), 1'b0);
      send_symbol(1'($urandom_range(0, 1)), 1'b1);
    end else if (pick == 14) begin
      send_sync();
      send_frame_bytes($urandom_range(0, frame_bytes.size()), 1'b0);
      k = $urandom_range(0, 5);
      send_group((k == 5) ? 3'b011 : ((k == 4) ? 3'b101 :
                 ((k == 3) ? 3'b111 : 3'(k))), 1'($urandom_range(0, 1)));
    end else begin
      if (pick == 13) frame_bytes[0] = 8'(body + 1 + $urandom_range(0, 254 - body));
      close_frame((pick == 12) ? 8'($urandom_range(1, 255)) : 8'd0);
      send_frame(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0) send_symbol(1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  task automatic test_random_traffic();
    logic [31:0] words[3];
    int w;
    int item_mark;
    int result_mark;
    int frames;
    words = '{SYNC_RESET, $urandom(), 32'hCCCC_AAAA};
    for (w = 0; w < 3; w++) begin
      write_sync(words[w]);
      item_mark   = symbols_counted;
      result_mark = results_promised;
      frames      = 0;
      while ((symbols_counted - item_mark < 60 || results_promised - result_mark < 25)
             && frames < 40) begin
        run_random_frame();
        frames++;
      end
      // a stretch with no idling on either side closes each phase
      in_idle_on   = 1'b0;
      out_stall_on = 1'b0;
      begin_frame(8'd1);
      add_random_body(4);
      close_frame(8'd0);
      send_frame(1'b0);
      in_idle_on   = 1'b1;
      out_stall_on = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_symbol      = 1'b0;
    in_capture_end = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    sync_m         = SYNC_RESET;
    back_to_hunt();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_good_frames();
    test_largest_frames();
    test_checksum_errors();
    test_sender_length();
    test_line_code();
    test_capture_end();
    test_buffer_overflow();
    test_sync_words();
    test_random_traffic();

    settle_block();
    $display("Run covered %0d symbol items in %0d frames and %0d checked results,",
             symbols_total, frames_sent, results_checked);
    $display("over several sync words, every frame error and random stalls on both sides.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
